/* design/wme_pkg.sv */
// Shared types and constants for the weight matrix engine.
// Used by the control, datapath and top-level modules; depends on nothing.
`default_nettype none

package wme_pkg;

   localparam int DATA_W       = 16;
   localparam int MAX_ROWS_DEF = 16;
   localparam int MAX_COLS_DEF = 16;
   localparam int CSR_IDX_W    = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ETA   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS  = 2'd3;

   localparam logic signed [DATA_W-1:0] ALPHA_RESET = 16'sd256;
   localparam logic signed [DATA_W-1:0] ETA_RESET   = 16'sd256;
   localparam logic [4:0]               ROWS_RESET  = 5'd16;
   localparam logic [4:0]               COLS_RESET  = 5'd16;
   localparam logic signed [DATA_W-1:0] ONE_Q88     = 16'sd256;

   typedef enum logic [2:0] {
      FUNC_WRITE     = 3'd0,
      FUNC_READ      = 3'd1,
      FUNC_LOAD_X    = 3'd2,
      FUNC_LOAD_Y    = 3'd3,
      FUNC_FORWARD   = 3'd4,
      FUNC_TRANSPOSE = 3'd5,
      FUNC_UPDATE    = 3'd6,
      FUNC_NOP       = 3'd7
   } func_type;

   typedef enum logic [2:0] {
      KIND_NONE,
      KIND_READ,
      KIND_FWD,
      KIND_TRN,
      KIND_UPD
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      logic        valid;
      logic        work;
      logic        last;
      kind_type    kind;
   } tag_type;

   typedef struct packed {
      logic              valid;
      logic [DATA_W-1:0] addend;
   } start_type;

   typedef struct packed {
      logic [DATA_W-1:0] alpha;
      logic [DATA_W-1:0] eta;
   } gains_type;

   typedef struct packed {
      logic              valid;
      logic [DATA_W-1:0] value;
      logic              flag;
   } res_type;

endpackage

`default_nettype wire

/* design/wme_store.sv */
// Weight memory and vector memory of the weight matrix engine.
// Synchronous RAMs with registered reads; uses no package items.
`default_nettype none

module wme_store #(
   parameter int  MAX_ROWS = 16,
   parameter int  MAX_COLS = 16,
   localparam int AW  = (MAX_ROWS * MAX_COLS > 1) ? $clog2(MAX_ROWS * MAX_COLS) : 1,
   localparam int VAW = $clog2(MAX_ROWS + MAX_COLS)
) (
   input  logic                clock,
   input  logic                host_w_we,
   input  logic [AW-1:0]       host_w_addr,
   input  logic signed [15:0]  host_w_data,
   input  logic                upd_we,
   input  logic [AW-1:0]       upd_addr,
   input  logic signed [15:0]  upd_data,
   input  logic [AW-1:0]       w_raddr,
   output logic signed [15:0]  w_rdata,
   input  logic                host_v_we,
   input  logic [VAW-1:0]      host_v_addr,
   input  logic signed [15:0]  host_v_data,
   input  logic [VAW-1:0]      va_raddr,
   input  logic [VAW-1:0]      vb_raddr,
   output logic signed [15:0]  va_rdata,
   output logic signed [15:0]  vb_rdata
);

   localparam int W_DEPTH = MAX_ROWS * MAX_COLS;
   localparam int V_DEPTH = MAX_ROWS + MAX_COLS;

   logic signed [15:0] wmem [W_DEPTH];
   logic signed [15:0] vmem [V_DEPTH];

   // The column vector sits at the low addresses, the row vector above it.
   always_ff @(posedge clock) begin
      if (upd_we) begin
         wmem[upd_addr] <= upd_data;
      end else if (host_w_we) begin
         wmem[host_w_addr] <= host_w_data;
      end
      w_rdata <= wmem[w_raddr];
   end

   always_ff @(posedge clock) begin
      if (host_v_we) begin
         vmem[host_v_addr] <= host_v_data;
      end
      va_rdata <= vmem[va_raddr];
      vb_rdata <= vmem[vb_raddr];
   end

endmodule

`default_nettype wire

/* design/wme_datapath.sv */
// Multiply, accumulate and weight update pipeline of the weight matrix engine.
// Depends on wme_pkg; consumes the registered read data of wme_store.
`default_nettype none

module wme_datapath #(
   parameter int  MAX_ROWS = wme_pkg::MAX_ROWS_DEF,
   parameter int  MAX_COLS = wme_pkg::MAX_COLS_DEF,
   localparam int AW = (MAX_ROWS * MAX_COLS > 1) ? $clog2(MAX_ROWS * MAX_COLS) : 1
) (
   input  logic                clock,
   input  logic                reset,
   input  wme_pkg::gains_type  gains,
   input  wme_pkg::start_type  start,
   input  wme_pkg::tag_type    tag,
   input  logic [AW-1:0]       waddr,
   input  logic signed [15:0]  w_rdata,
   input  logic signed [15:0]  va_rdata,
   input  logic signed [15:0]  vb_rdata,
   output logic                upd_we,
   output logic [AW-1:0]       upd_addr,
   output logic signed [15:0]  upd_data,
   output wme_pkg::res_type    res
);

   import wme_pkg::*;

   localparam int MAX_DIM = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
   localparam int ACC_W   = 34 + $clog2(MAX_DIM);

   typedef struct packed {
      logic        clip;
      logic [15:0] value;
   } sat_type;

   function automatic sat_type sat16(input logic signed [47:0] v);
      sat_type s;
      if (v > 48'sd32767) begin
         s.clip  = 1'b1;
         s.value = 16'h7fff;
      end else if (v < -48'sd32768) begin
         s.clip  = 1'b1;
         s.value = 16'h8000;
      end else begin
         s.clip  = 1'b0;
         s.value = v[15:0];
      end
      return s;
   endfunction

   tag_type             tag1_ff, tag2_ff, tag3_ff;
   logic [AW-1:0]       waddr1_ff, waddr2_ff, waddr3_ff;
   logic signed [15:0]  op_b;
   logic signed [31:0]  m1_in, m1_ff, m2_in, m2_ff, m1d_ff;
   logic signed [47:0]  m3_in, m3_ff;
   logic signed [ACC_W-1:0] acc_in, acc_ff;
   logic signed [48:0]  upd_sum;
   sat_type             upd_sat, acc_sat;
   logic                sat_any_in, sat_any_ff;

   always_comb begin
      if (tag1_ff.kind == KIND_UPD) begin
         op_b = $signed(gains.alpha);
      end else if (tag1_ff.kind == KIND_READ) begin
         op_b = ONE_Q88;
      end else begin
         op_b = va_rdata;
      end
      m1_in = w_rdata * op_b;
      m2_in = va_rdata * vb_rdata;
      m3_in = $signed(gains.eta) * m2_ff;
   end

   always_comb begin
      acc_in = acc_ff;
      if (start.valid) begin
         acc_in = ACC_W'($signed({start.addend, 8'h00}));
      end else if (tag2_ff.valid && tag2_ff.work && tag2_ff.kind != KIND_UPD) begin
         acc_in = acc_ff + ACC_W'(m1_ff);
      end
   end

   always_comb begin
      upd_sum  = (49'(m1d_ff) <<< 8) + 49'(m3_ff);
      upd_sat  = sat16(48'(upd_sum >>> 16));
      acc_sat  = sat16(48'(acc_ff >>> 8));
      upd_we   = tag3_ff.valid && tag3_ff.work && (tag3_ff.kind == KIND_UPD);
      upd_addr = waddr3_ff;
      upd_data = upd_sat.value;

      sat_any_in = sat_any_ff | (upd_we & upd_sat.clip);
      if (start.valid) begin
         sat_any_in = 1'b0;
      end

      res.valid = tag3_ff.valid && tag3_ff.last;
      if (tag3_ff.kind == KIND_UPD) begin
         res.value = '0;
         res.flag  = sat_any_ff | (upd_we & upd_sat.clip);
      end else begin
         res.value = acc_sat.value;
         res.flag  = acc_sat.clip;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff    <= '0;
         tag2_ff    <= '0;
         tag3_ff    <= '0;
         sat_any_ff <= 1'b0;
      end else begin
         tag1_ff    <= tag;
         tag2_ff    <= tag1_ff;
         tag3_ff    <= tag2_ff;
         sat_any_ff <= sat_any_in;
      end
   end

   always_ff @(posedge clock) begin
      waddr1_ff <= waddr;
      waddr2_ff <= waddr1_ff;
      waddr3_ff <= waddr2_ff;
      m1_ff     <= m1_in;
      m2_ff     <= m2_in;
      m1d_ff    <= m1_ff;
      m3_ff     <= m3_in;
      acc_ff    <= acc_in;
   end

endmodule

`default_nettype wire

/* design/wme_ctrl.sv */
// Sequencer, configuration registers and response buffering of the engine.
// Depends on wme_pkg; drives wme_store addresses and wme_datapath tags.
`default_nettype none

module wme_ctrl #(
   parameter int  MAX_ROWS = wme_pkg::MAX_ROWS_DEF,
   parameter int  MAX_COLS = wme_pkg::MAX_COLS_DEF,
   localparam int AW  = (MAX_ROWS * MAX_COLS > 1) ? $clog2(MAX_ROWS * MAX_COLS) : 1,
   localparam int VAW = $clog2(MAX_ROWS + MAX_COLS)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [2:0]                    req_func,
   input  logic [3:0]                    req_row,
   input  logic [3:0]                    req_col,
   input  logic signed [15:0]            req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [15:0]            rsp_result_value,
   output logic                          rsp_saturated,
   input  logic                          csr_we,
   input  logic [wme_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]                   csr_wdata,
   output wme_pkg::gains_type            gains,
   output wme_pkg::start_type            start,
   output wme_pkg::tag_type              tag,
   output logic [AW-1:0]                 w_raddr,
   output logic [VAW-1:0]                va_raddr,
   output logic [VAW-1:0]                vb_raddr,
   output logic                          host_w_we,
   output logic [AW-1:0]                 host_w_addr,
   output logic signed [15:0]            host_w_data,
   output logic                          host_v_we,
   output logic [VAW-1:0]                host_v_addr,
   output logic signed [15:0]            host_v_data,
   input  wme_pkg::res_type              res
);

   import wme_pkg::*;

   localparam int RIDX_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CIDX_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int RCNT_W = $clog2(MAX_ROWS + 1);
   localparam int CCNT_W = $clog2(MAX_COLS + 1);

   state_type           state_ff, state_in;
   kind_type            kind_ff, kind_in;
   logic                work_ff, work_in;
   logic [RIDX_W-1:0]   i_ff, i_in, last_i_ff, last_i_in;
   logic [CIDX_W-1:0]   j_ff, j_in, last_j_ff, last_j_in;
   logic signed [15:0]  alpha_ff, eta_ff;
   logic [4:0]          rows_used_ff, cols_used_ff;
   logic [RCNT_W-1:0]   nr;
   logic [CCNT_W-1:0]   nc;
   logic                row_ok, col_ok, row_used, col_used;
   logic                accept, step_last, move;
   logic                pend_valid_ff, pend_valid_in, pend_flag_ff, pend_flag_in;
   logic [15:0]         pend_value_ff, pend_value_in;
   logic                rsp_valid_ff, rsp_valid_in, rsp_flag_ff, rsp_flag_in;
   logic [15:0]         rsp_value_ff, rsp_value_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff     <= ALPHA_RESET;
         eta_ff       <= ETA_RESET;
         rows_used_ff <= ROWS_RESET;
         cols_used_ff <= COLS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ALPHA: alpha_ff <= csr_wdata;
            CSR_ETA: eta_ff <= csr_wdata;
            CSR_ROWS: rows_used_ff <= csr_wdata[4:0];
            CSR_COLS: cols_used_ff <= csr_wdata[4:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      gains.alpha = alpha_ff;
      gains.eta   = eta_ff;
      nr = (32'(rows_used_ff) > MAX_ROWS) ? RCNT_W'(MAX_ROWS) : RCNT_W'(rows_used_ff);
      nc = (32'(cols_used_ff) > MAX_COLS) ? CCNT_W'(MAX_COLS) : CCNT_W'(cols_used_ff);
      row_ok   = 32'(req_row) < MAX_ROWS;
      col_ok   = 32'(req_col) < MAX_COLS;
      row_used = 32'(req_row) < 32'(nr);
      col_used = 32'(req_col) < 32'(nc);
      host_w_addr = AW'(32'(req_row) * MAX_COLS + 32'(req_col));
      host_w_data = req_value;
      host_v_data = req_value;
      w_raddr  = AW'(32'(i_ff) * MAX_COLS + 32'(j_ff));
      vb_raddr = VAW'(MAX_COLS + 32'(i_ff));
      va_raddr = (kind_ff == KIND_TRN) ? vb_raddr : VAW'(32'(j_ff));
   end

   always_comb begin
      state_in  = state_ff;
      kind_in   = kind_ff;
      work_in   = work_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      last_i_in = last_i_ff;
      last_j_in = last_j_ff;
      req_ready = 1'b0;
      accept    = 1'b0;
      start     = '0;
      tag       = '0;
      host_w_we = 1'b0;
      host_v_we = 1'b0;
      host_v_addr = VAW'(32'(req_col));
      step_last = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_ready = !pend_valid_ff;
            accept    = req_valid && !pend_valid_ff;
            if (accept) begin
               state_in    = ST_RUN;
               kind_in     = KIND_NONE;
               work_in     = 1'b0;
               i_in        = RIDX_W'(req_row);
               j_in        = CIDX_W'(req_col);
               last_i_in   = RIDX_W'(nr - 1'b1);
               last_j_in   = CIDX_W'(nc - 1'b1);
               start.valid = 1'b1;
               case (func_type'(req_func))
                  FUNC_WRITE: begin
                     host_w_we = row_ok && col_ok;
                  end
                  FUNC_READ: begin
                     kind_in = KIND_READ;
                     work_in = row_ok && col_ok;
                  end
                  FUNC_LOAD_X: begin
                     host_v_we = col_ok;
                  end
                  FUNC_LOAD_Y: begin
                     host_v_we   = row_ok;
                     host_v_addr = VAW'(MAX_COLS + 32'(req_row));
                  end
                  FUNC_FORWARD: begin
                     kind_in      = KIND_FWD;
                     work_in      = row_used && (nc != '0);
                     j_in         = '0;
                     start.addend = req_value;
                  end
                  FUNC_TRANSPOSE: begin
                     kind_in      = KIND_TRN;
                     work_in      = col_used && (nr != '0);
                     i_in         = '0;
                     start.addend = req_value;
                  end
                  FUNC_UPDATE: begin
                     kind_in = KIND_UPD;
                     work_in = (nr != '0) && (nc != '0);
                     i_in    = '0;
                     j_in    = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_RUN: begin
            tag.valid = 1'b1;
            tag.work  = work_ff;
            tag.kind  = kind_ff;
            if (work_ff) begin
               case (kind_ff)
                  KIND_FWD: begin
                     step_last = (j_ff == last_j_ff);
                     j_in      = j_ff + 1'b1;
                  end
                  KIND_TRN: begin
                     step_last = (i_ff == last_i_ff);
                     i_in      = i_ff + 1'b1;
                  end
                  KIND_UPD: begin
                     step_last = (i_ff == last_i_ff) && (j_ff == last_j_ff);
                     if (j_ff == last_j_ff) begin
                        j_in = '0;
                        i_in = i_ff + 1'b1;
                     end else begin
                        j_in = j_ff + 1'b1;
                     end
                  end
                  default: begin
                     step_last = 1'b1;
                  end
               endcase
            end
            tag.last = step_last;
            if (step_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (res.valid) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // A finished result waits in the pending register while the output stalls.
   always_comb begin
      move          = pend_valid_ff && (!rsp_valid_ff || rsp_ready);
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_value_in  = rsp_value_ff;
      rsp_flag_in   = rsp_flag_ff;
      pend_valid_in = pend_valid_ff && !move;
      pend_value_in = pend_value_ff;
      pend_flag_in  = pend_flag_ff;
      if (move) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = pend_value_ff;
         rsp_flag_in  = pend_flag_ff;
      end
      if (res.valid) begin
         pend_valid_in = 1'b1;
         pend_value_in = res.value;
         pend_flag_in  = res.flag;
      end
      rsp_valid        = rsp_valid_ff;
      rsp_result_value = rsp_value_ff;
      rsp_saturated    = rsp_flag_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         kind_ff       <= KIND_NONE;
         work_ff       <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         kind_ff       <= kind_in;
         work_ff       <= work_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff          <= i_in;
      j_ff          <= j_in;
      last_i_ff     <= last_i_in;
      last_j_ff     <= last_j_in;
      pend_value_ff <= pend_value_in;
      pend_flag_ff  <= pend_flag_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_flag_ff   <= rsp_flag_in;
   end

   a_res_in_drain: assert property (@(posedge clock) disable iff (reset)
      res.valid |-> (state_ff == ST_DRAIN) && !pend_valid_ff)
      else $error("result arrived outside the drain phase or over a pending result");

   a_accept_runs: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_RUN))
      else $error("accepted transfer did not start the sequencer");

   a_rsp_from_pend: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(pend_valid_ff))
      else $error("response raised without a pending result");

endmodule

`default_nettype wire

/* design/weight_matrix_engine_top.sv */
// Top level of the weight matrix engine: sequencer, datapath and memories.
// Depends on wme_pkg, wme_ctrl, wme_datapath and wme_store.
//
// Usage: items enter on the req_ channel (valid/ready) and each item gives
// exactly one response on the rsp_ channel (valid/ready). A transfer on req_
// writes or reads a weight, loads an x or y element, computes one forward
// row or transposed column, updates every weight in use, or does nothing.
// Gains and the rows/columns in use are written through
// csr_we/csr_index/csr_wdata while the engine is idle.
// An item that walks n weights (n = columns in use for a forward row, rows
// in use for a transposed column, rows times columns for an update) reads
// one weight per cycle from the single read port of the weight memory. A
// new item is taken only once the previous one has given its result and
// the pending register is empty.
// Reset clears the control state and loads the gains with 1.0 and the rows
// and columns in use with 16; memory contents are undefined until written.
// When the receiver stalls, the engine still takes one more item; its result
// waits in a pending register, which holds off further transfers.
`default_nettype none

module weight_matrix_engine_top #(
   parameter int MAX_ROWS = wme_pkg::MAX_ROWS_DEF,
   parameter int MAX_COLS = wme_pkg::MAX_COLS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [2:0]                    req_func,
   input  logic [3:0]                    req_row,
   input  logic [3:0]                    req_col,
   input  logic signed [15:0]            req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [15:0]            rsp_result_value,
   output logic                          rsp_saturated,
   input  logic                          csr_we,
   input  logic [wme_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]                   csr_wdata
);

   import wme_pkg::*;

   localparam int AW  = (MAX_ROWS * MAX_COLS > 1) ? $clog2(MAX_ROWS * MAX_COLS) : 1;
   localparam int VAW = $clog2(MAX_ROWS + MAX_COLS);

   gains_type          gains;
   start_type          start;
   tag_type            tag;
   res_type            res;
   logic [AW-1:0]      w_raddr, host_w_addr, upd_addr;
   logic [VAW-1:0]     va_raddr, vb_raddr, host_v_addr;
   logic               host_w_we, host_v_we, upd_we;
   logic signed [15:0] host_w_data, host_v_data, upd_data;
   logic signed [15:0] w_rdata, va_rdata, vb_rdata;

   wme_ctrl #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_row          (req_row),
      .req_col          (req_col),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_value (rsp_result_value),
      .rsp_saturated    (rsp_saturated),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .gains            (gains),
      .start            (start),
      .tag              (tag),
      .w_raddr          (w_raddr),
      .va_raddr         (va_raddr),
      .vb_raddr         (vb_raddr),
      .host_w_we        (host_w_we),
      .host_w_addr      (host_w_addr),
      .host_w_data      (host_w_data),
      .host_v_we        (host_v_we),
      .host_v_addr      (host_v_addr),
      .host_v_data      (host_v_data),
      .res              (res)
   );

   wme_datapath #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .gains    (gains),
      .start    (start),
      .tag      (tag),
      .waddr    (w_raddr),
      .w_rdata  (w_rdata),
      .va_rdata (va_rdata),
      .vb_rdata (vb_rdata),
      .upd_we   (upd_we),
      .upd_addr (upd_addr),
      .upd_data (upd_data),
      .res      (res)
   );

   wme_store #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_store (
      .clock       (clock),
      .host_w_we   (host_w_we),
      .host_w_addr (host_w_addr),
      .host_w_data (host_w_data),
      .upd_we      (upd_we),
      .upd_addr    (upd_addr),
      .upd_data    (upd_data),
      .w_raddr     (w_raddr),
      .w_rdata     (w_rdata),
      .host_v_we   (host_v_we),
      .host_v_addr (host_v_addr),
      .host_v_data (host_v_data),
      .va_raddr    (va_raddr),
      .vb_raddr    (vb_raddr),
      .va_rdata    (va_rdata),
      .vb_rdata    (vb_rdata)
   );

endmodule

`default_nettype wire

/* test/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for weight_matrix_engine_top: a shadow copy of the matrix,
// vectors and gains predicts each response. Depends on wme_pkg and the engine RTL.

module testbench;
   import wme_pkg::*;

   typedef struct packed {
      logic [15:0] value;
      logic        clipped;
   } outcome_type;

   class matrix_shadow_type;
      shortint  weights [MAX_ROWS_DEF][MAX_COLS_DEF];
      shortint  x_vec [MAX_COLS_DEF];
      shortint  y_vec [MAX_ROWS_DEF];
      shortint  alpha;
      shortint  eta;
      logic [4:0] rows_used;
      logic [4:0] cols_used;
      outcome_type due_outcomes [$];
      int       errors;
      int       n_items;
      int       n_checked;
      int       n_clipped;
      int       n_by_func [8];

      function new();
         alpha     = ALPHA_RESET;
         eta       = ETA_RESET;
         rows_used = ROWS_RESET;
         cols_used = COLS_RESET;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [15:0] data);
         case (idx)
            CSR_ALPHA: alpha = data;
            CSR_ETA:   eta = data;
            CSR_ROWS:  rows_used = data[4:0];
            CSR_COLS:  cols_used = data[4:0];
            default: ;
         endcase
      endfunction

      function shortint clip16(longint v, inout bit flag);
         if (v > 32767) begin
            flag = 1'b1;
            return 16'sh7FFF;
         end
         if (v < -32768) begin
            flag = 1'b1;
            return -16'sh8000;
         end
         return shortint'(v);
      endfunction

      function void take_item(func_type f, logic [3:0] r, logic [3:0] c, shortint v);
         outcome_type o;
         longint   acc;
         bit       clip;
         int       nr;
         int       nc;
         clip    = 1'b0;
         o.value = '0;
         nr = (rows_used > MAX_ROWS_DEF) ? MAX_ROWS_DEF : rows_used;
         nc = (cols_used > MAX_COLS_DEF) ? MAX_COLS_DEF : cols_used;
         case (f)
            FUNC_WRITE:  weights[r][c] = v;
            FUNC_READ:   o.value = weights[r][c];
            FUNC_LOAD_X: x_vec[c] = v;
            FUNC_LOAD_Y: y_vec[r] = v;
            FUNC_FORWARD: begin
               acc = longint'(v) * 256;
               if (r < nr)
                  for (int j = 0; j < nc; j++)
                     acc += longint'(weights[r][j]) * longint'(x_vec[j]);
               o.value = clip16(acc >>> 8, clip);
            end
            FUNC_TRANSPOSE: begin
               acc = longint'(v) * 256;
               if (c < nc)
                  for (int i = 0; i < nr; i++)
                     acc += longint'(y_vec[i]) * longint'(weights[i][c]);
               o.value = clip16(acc >>> 8, clip);
            end
            FUNC_UPDATE: begin
               for (int i = 0; i < nr; i++)
                  for (int j = 0; j < nc; j++) begin
                     acc = longint'(alpha) * longint'(weights[i][j]) * 256
                         + longint'(eta) * longint'(y_vec[i]) * longint'(x_vec[j]);
                     weights[i][j] = clip16(acc >>> 16, clip);
                  end
            end
            default: ;
         endcase
         o.clipped = clip;
         due_outcomes.push_back(o);
         n_items++;
         n_by_func[f]++;
      endfunction

      function void match_response(logic [15:0] value, logic clipped);
         outcome_type o;
         n_checked++;
         if (due_outcomes.size() == 0) begin
            $error("unexpected response: result_value %0d, saturated %0b",
                   $signed(value), clipped);
            errors++;
            return;
         end
         o = due_outcomes.pop_front();
         if (clipped) n_clipped++;
         if (value !== o.value) begin
            $error("result_value: expected %0d, got %0d", $signed(o.value), $signed(value));
            errors++;
         end
         if (clipped !== o.clipped) begin
            $error("saturated: expected %0b, got %0b", o.clipped, clipped);
            errors++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [2:0]            req_func = FUNC_NOP;
   logic [3:0]            req_row = '0;
   logic [3:0]            req_col = '0;
   logic signed [15:0]    req_value = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic signed [15:0]    rsp_result_value;
   logic                  rsp_saturated;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_ALPHA;
   logic [15:0]           csr_wdata = '0;
   bit                    quiet = 1'b0;
   matrix_shadow_type     shadow = new();

   weight_matrix_engine_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_row          (req_row),
      .req_col          (req_col),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_value (rsp_result_value),
      .rsp_saturated    (rsp_saturated),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial forever #5 clock = ~clock;

   initial begin
      int stall;
      stall = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready)
            shadow.match_response(rsp_result_value, rsp_saturated);
         if (!quiet && stall == 0 && $urandom_range(0, 4) == 0)
            stall = $urandom_range(1, 6);
         if (quiet) stall = 0;
         rsp_ready <= (stall == 0);
         if (stall > 0) stall--;
      end
   end

   function automatic logic signed [15:0] rand_value();
      int t;
      case ($urandom_range(0, 9))
         0:       return ($urandom_range(0, 1) == 1) ? 16'sh7FFF : -16'sh8000;
         1, 2, 3: return 16'($urandom);
         default: begin
            t = int'($urandom_range(0, 1023)) - 512;
            return 16'(t);
         end
      endcase
   endfunction

   task automatic send_item(input func_type f, input logic [3:0] r, input logic [3:0] c,
                            input logic signed [15:0] v);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func  <= f;
      req_row   <= r;
      req_col   <= c;
      req_value <= v;
      do @(posedge clock); while (!req_ready);
      shadow.take_item(f, r, c, v);
   endtask

   task automatic drain_engine();
      req_valid <= 1'b0;
      @(posedge clock);
      while (shadow.due_outcomes.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic apply_config(input logic [15:0] a, input logic [15:0] e,
                               input logic [4:0] nr, input logic [4:0] nc);
      logic [15:0] reg_val [4];
      drain_engine();
      reg_val[CSR_ALPHA] = a;
      reg_val[CSR_ETA]   = e;
      reg_val[CSR_ROWS]  = {11'($urandom), nr};
      reg_val[CSR_COLS]  = {11'($urandom), nc};
      for (int k = 0; k < 4; k++) begin
         csr_we    <= 1'b1;
         csr_index <= CSR_IDX_W'(k);
         csr_wdata <= reg_val[k];
         @(posedge clock);
         shadow.write_reg(CSR_IDX_W'(k), reg_val[k]);
      end
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_item();
      func_type f;
      case ($urandom_range(0, 99)) inside
         [0:14]:  f = FUNC_WRITE;
         [15:29]: f = FUNC_READ;
         [30:41]: f = FUNC_LOAD_X;
         [42:53]: f = FUNC_LOAD_Y;
         [54:74]: f = FUNC_FORWARD;
         [75:94]: f = FUNC_TRANSPOSE;
         [95:97]: f = FUNC_UPDATE;
         default: f = FUNC_NOP;
      endcase
      send_item(f, 4'($urandom), 4'($urandom), rand_value());
   endtask

   task automatic run_phase(input logic [15:0] a, input logic [15:0] e,
                            input logic [4:0] nr, input logic [4:0] nc, input int count);
      apply_config(a, e, nr, nc);
      repeat (count) random_item();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Every store entry is written before anything can read it.
      for (int r = 0; r < MAX_ROWS_DEF; r++)
         for (int c = 0; c < MAX_COLS_DEF; c++)
            send_item(FUNC_WRITE, 4'(r), 4'(c), rand_value());
      for (int k = 0; k < MAX_COLS_DEF; k++) send_item(FUNC_LOAD_X, 4'd0, 4'(k), rand_value());
      for (int k = 0; k < MAX_ROWS_DEF; k++) send_item(FUNC_LOAD_Y, 4'(k), 4'd0, rand_value());

      send_item(FUNC_WRITE, 4'd0, 4'd0, 16'sh7FFF);
      send_item(FUNC_WRITE, 4'd15, 4'd15, -16'sh8000);
      send_item(FUNC_READ, 4'd0, 4'd0, 16'sd0);
      send_item(FUNC_READ, 4'd15, 4'd15, -16'sd1);
      send_item(FUNC_LOAD_X, 4'd0, 4'd0, -16'sh8000);
      send_item(FUNC_LOAD_Y, 4'd15, 4'd15, 16'sh7FFF);
      send_item(FUNC_FORWARD, 4'd0, 4'd3, 16'sd0);
      send_item(FUNC_FORWARD, 4'd15, 4'd0, -16'sh8000);
      send_item(FUNC_TRANSPOSE, 4'd2, 4'd0, 16'sh7FFF);
      send_item(FUNC_TRANSPOSE, 4'd0, 4'd15, 16'sd0);
      send_item(FUNC_NOP, 4'd15, 4'd15, -16'sd1);
      send_item(FUNC_UPDATE, 4'd0, 4'd0, 16'sd0);
      send_item(FUNC_READ, 4'd15, 4'd15, 16'sd0);

      // No rows or columns in use: products give the addend, update changes nothing.
      apply_config(16'sd256, 16'sd256, 5'd0, 5'd0);
      send_item(FUNC_FORWARD, 4'd3, 4'd3, 16'sd1234);
      send_item(FUNC_TRANSPOSE, 4'd3, 4'd3, -16'sd77);
      send_item(FUNC_UPDATE, 4'd0, 4'd0, 16'sd0);
      send_item(FUNC_READ, 4'd0, 4'd0, 16'sd0);

      // Row outside the rows in use, then counts above the maximum.
      apply_config(16'sd128, 16'sd64, 5'd3, 5'd31);
      send_item(FUNC_FORWARD, 4'd10, 4'd0, 16'sd500);
      send_item(FUNC_FORWARD, 4'd1, 4'd0, 16'sd0);
      send_item(FUNC_TRANSPOSE, 4'd0, 4'd2, 16'sd0);
      apply_config(16'sd256, 16'sd16, 5'd31, 5'd5);
      send_item(FUNC_TRANSPOSE, 4'd0, 4'd9, -16'sd300);
      send_item(FUNC_FORWARD, 4'd15, 4'd0, 16'sd0);

      run_phase(16'sd256, 16'sd256, 5'd16, 5'd16, 50);
      run_phase(16'sd128, 16'sd32, 5'd4, 5'd7, 50);
      run_phase(16'h8000, 16'h7FFF, 5'd2, 5'd3, 50);
      run_phase(16'h7FFF, 16'h8000, 5'd1, 5'd1, 50);
      run_phase(16'sd0, 16'sd256, 5'd16, 5'd16, 50);
      run_phase(16'sd256, 16'sd0, 5'd8, 5'd16, 40);
      run_phase(16'($urandom), 16'($urandom), 5'($urandom), 5'($urandom), 50);
      drain_engine();
      quiet = 1'b1;
      run_phase(16'sd256, 16'sd16, 5'd5, 5'd5, 50);

      drain_engine();
      repeat (20) @(posedge clock);
      $display("Checked %0d responses from %0d transfers: %0d forward rows, %0d columns,",
               shadow.n_checked, shadow.n_items, shadow.n_by_func[FUNC_FORWARD],
               shadow.n_by_func[FUNC_TRANSPOSE]);
      $display("%0d updates, %0d saturated responses, over eleven register settings.",
               shadow.n_by_func[FUNC_UPDATE], shadow.n_clipped);
      if (shadow.errors == 0)
         $display("PASS weight_matrix_engine_top");
      else
         $display("FAIL weight_matrix_engine_top");
      $finish;
   end

   initial begin
      #(15_000_000);
      $display("FAIL weight_matrix_engine_top");
      $finish;
   end

endmodule

/* filelist.f */
design/wme_pkg.sv
design/wme_store.sv
design/wme_datapath.sv
design/wme_ctrl.sv
design/weight_matrix_engine_top.sv
test/testbench.sv
